### design/fsrd_pkg.sv
package fsrd_pkg;

  // Pixel channels and error storage
  localparam int PIX_W     = 8;
  localparam int NUM_CH    = 3;
  localparam int ERR_W     = 10;
  localparam int MEM_W     = NUM_CH * ERR_W;
  localparam int SUM_W     = ERR_W + 2;
  localparam int DIFF_W    = PIX_W + 1;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int LINE_W    = 12;
  localparam logic REG_LEVELS     = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;
  localparam logic [PIX_W-1:0]  LEVELS_RESET = 8'd1;
  localparam logic [LINE_W-1:0] WIDTH_RESET  = 12'd640;
  localparam int MIN_WIDTH = 2;
  localparam int MAX_WIDTH_DEFAULT = 2048;

  // Quantiser arithmetic: floor(y / 255) as (y * DIV255_MULT) >> DIV255_SHIFT for 16-bit y
  localparam int Y_W = 16;
  localparam logic [Y_W-1:0] Y_ROUND = 16'd127;
  localparam logic [Y_W-1:0] DIV255_MULT = 16'h8081;
  localparam int DIV255_SHIFT = 23;

  // Reciprocal of levels: ceil(2^RECIP_SHIFT / levels)
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Diffusion weights in sixteenths
  localparam logic [2:0] SHARE_RIGHT      = 3'd7;
  localparam logic [2:0] SHARE_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] SHARE_DOWN       = 3'd5;
  localparam logic [2:0] SHARE_DOWN_RIGHT = 3'd1;

  // Stage strobes from the sequencer to each channel datapath
  typedef struct packed {
    logic clear;
    logic sum;
    logic mul1;
    logic mul2;
    logic mul3;
    logic commit;
  } chan_ctrl_t;

  // Weighted share of an error, truncated toward zero.
  function automatic logic signed [ERR_W-1:0] share(input logic signed [DIFF_W-1:0] e,
                                                    input logic [2:0] num);
    logic [DIFF_W-1:0]       mag;
    logic [DIFF_W+2:0]       prod;
    logic signed [ERR_W-1:0] s;
    mag  = e[DIFF_W-1] ? DIFF_W'(-e) : DIFF_W'(e);
    prod = (DIFF_W+3)'(mag) * (DIFF_W+3)'(num);
    s    = $signed(ERR_W'(prod >> 4));
    return e[DIFF_W-1] ? ERR_W'(-s) : s;
  endfunction

endpackage

### design/fsrd_recip.sv
// Restoring divider producing ceil(2^RECIP_SHIFT / divisor), one quotient bit per cycle.
module fsrd_recip (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [fsrd_pkg::PIX_W-1:0]          divisor,
  output logic [fsrd_pkg::RECIP_W-1:0]        recip,
  output logic                                busy
);

  localparam int RW    = fsrd_pkg::RECIP_W;
  localparam int DW    = fsrd_pkg::PIX_W;
  localparam int CNT_W = $clog2(RW);

  logic [RW-1:0]    sh;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic             fits;

  // One restoring step: bring down the next numerator bit and try a subtraction.
  assign trial = {rem, sh[RW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      sh   <= RW'(1) << fsrd_pkg::RECIP_SHIFT;
      rem  <= '0;
      dvs  <= DW'(1);
    end else if (start) begin
      // Numerator 2^N + d - 1 turns the floor division into a ceiling.
      busy <= 1'b1;
      cnt  <= '0;
      dvs  <= divisor;
      rem  <= '0;
      sh   <= (RW'(1) << fsrd_pkg::RECIP_SHIFT) + RW'(divisor) - RW'(1);
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dvs}) : DW'(trial);
      sh  <= {sh[RW-2:0], fits};
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(RW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign recip = sh;

endmodule

### design/fsrd_chan.sv
// One colour channel: error add and clamp, quantise, error split and row carries.
module fsrd_chan (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fsrd_pkg::chan_ctrl_t                 ctrl,
  input  logic [fsrd_pkg::PIX_W-1:0]           pix_in,
  input  logic signed [fsrd_pkg::ERR_W-1:0]    below,
  input  logic [fsrd_pkg::PIX_W-1:0]           lv,
  input  logic [fsrd_pkg::RECIP_W-1:0]         recip,
  input  logic                                 last,
  output logic [fsrd_pkg::PIX_W-1:0]           pix_out,
  output logic signed [fsrd_pkg::ERR_W-1:0]    wr_prev,
  output logic signed [fsrd_pkg::ERR_W-1:0]    npb
);

  localparam int PW   = fsrd_pkg::PIX_W;
  localparam int EW   = fsrd_pkg::ERR_W;
  localparam int SW   = fsrd_pkg::SUM_W;
  localparam int YW   = fsrd_pkg::Y_W;
  localparam int P2_W = 2 * YW;
  localparam int P3_W = fsrd_pkg::RECIP_W + YW;
  localparam logic signed [SW-1:0] PIX_MAX = SW'(255);

  logic signed [EW-1:0] rc;
  logic signed [EW-1:0] pb;
  logic signed [EW-1:0] pbr;
  logic [PW-1:0]        v;
  logic [YW-1:0]        y;
  logic [PW-1:0]        q;
  logic [PW-1:0]        o;

  logic signed [SW-1:0]                 sum;
  logic [PW-1:0]                        v_next;
  logic [P2_W-1:0]                      p2;
  logic [YW-1:0]                        n;
  logic [P3_W-1:0]                      p3;
  logic signed [fsrd_pkg::DIFF_W-1:0]   e;
  logic signed [EW-1:0]                 sh_right;
  logic signed [EW-1:0]                 sh_dl;
  logic signed [EW-1:0]                 sh_down;
  logic signed [EW-1:0]                 sh_dr;

  // Input plus diffused error, clamped to the pixel range.
  always_comb begin
    sum = $signed(SW'(pix_in)) + SW'(rc) + SW'(below);
    if (sum < 0) begin
      v_next = '0;
    end else if (sum > PIX_MAX) begin
      v_next = '1;
    end else begin
      v_next = PW'(sum);
    end
  end

  // Quantiser products.
  assign p2 = P2_W'(y) * P2_W'(fsrd_pkg::DIV255_MULT);
  assign n  = {q, {PW{1'b0}}} - YW'(q);
  assign p3 = P3_W'(n) * P3_W'(recip);

  // Quantisation error and its four shares.
  assign e        = $signed({1'b0, v}) - $signed({1'b0, o});
  assign sh_right = fsrd_pkg::share(e, fsrd_pkg::SHARE_RIGHT);
  assign sh_dl    = fsrd_pkg::share(e, fsrd_pkg::SHARE_DOWN_LEFT);
  assign sh_down  = fsrd_pkg::share(e, fsrd_pkg::SHARE_DOWN);
  assign sh_dr    = fsrd_pkg::share(e, fsrd_pkg::SHARE_DOWN_RIGHT);
  assign wr_prev  = pb + sh_dl;
  assign npb      = pbr + sh_down;
  assign pix_out  = o;

  // Datapath stage registers.
  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      v <= v_next;
    end
    if (ctrl.mul1) begin
      y <= YW'(lv) * YW'(v) + fsrd_pkg::Y_ROUND;
    end
    if (ctrl.mul2) begin
      q <= PW'(p2 >> fsrd_pkg::DIV255_SHIFT);
    end
    if (ctrl.mul3) begin
      o <= PW'(p3 >> fsrd_pkg::RECIP_SHIFT);
    end
  end

  // Carries along the row; cleared at reset, frame start and row end.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      rc  <= '0;
      pb  <= '0;
      pbr <= '0;
    end else if (ctrl.commit) begin
      if (last) begin
        rc  <= '0;
        pb  <= '0;
        pbr <= '0;
      end else begin
        rc  <= sh_right;
        pb  <= npb;
        pbr <= sh_dr;
      end
    end
  end

endmodule

### design/floyd_steinberg_rgb_dither_unit.sv
// An input transaction steps through ST_SUM, ST_MUL1, ST_MUL2, ST_MUL3 and ST_COMMIT;
// out_valid rises at commit once the output is free. A new pixel is taken only in
// ST_IDLE, after that commit and, at the last column of a row, after ST_WLAST, the
// line buffer write that the single write port needs. A levels write holds off input
// while the reciprocal divider runs. Reset clears the carries and column count and
// starts a first row; the line buffer is not cleared and needs no clearing pass.
module floyd_steinberg_rgb_dither_unit #(
  parameter int MAX_WIDTH = fsrd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsrd_pkg::PIX_W-1:0]    red_in,
  input  logic [fsrd_pkg::PIX_W-1:0]    green_in,
  input  logic [fsrd_pkg::PIX_W-1:0]    blue_in,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fsrd_pkg::PIX_W-1:0]    red_out,
  output logic [fsrd_pkg::PIX_W-1:0]    green_out,
  output logic [fsrd_pkg::PIX_W-1:0]    blue_out,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [fsrd_pkg::CFG_W-1:0]    cfg_data
);

  localparam int PW = fsrd_pkg::PIX_W;
  localparam int EW = fsrd_pkg::ERR_W;
  localparam int MW = fsrd_pkg::MEM_W;
  localparam int NC = fsrd_pkg::NUM_CH;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > fsrd_pkg::LINE_W) ? AW + 1 : fsrd_pkg::LINE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMMIT,
    ST_WLAST
  } state_t;

  state_t                     state;
  logic [PW-1:0]              levels;
  logic [fsrd_pkg::LINE_W-1:0] line_width;
  logic [AW-1:0]              column_count;
  logic                       first_row;
  logic [AW-1:0]              col;
  logic                       last_col;
  logic [PW-1:0]              pix [NC];
  logic [MW-1:0]              last_data;

  logic [MW-1:0]              line_buf [MAX_WIDTH];
  logic [MW-1:0]              rd_data;
  logic                       mem_we;
  logic [AW-1:0]              wr_addr;
  logic [MW-1:0]              wr_data;

  logic                       in_fire;
  logic                       out_free;
  logic [PW-1:0]              lv;
  logic [PW-1:0]              cfg_lv;
  logic [CW-1:0]              w_raw;
  logic [CW-1:0]              w_eff;
  logic [AW-1:0]              w_last;
  logic [AW-1:0]              col_base;
  logic [AW-1:0]              c_in;
  logic                       recip_start;
  logic                       recip_busy;
  logic [fsrd_pkg::RECIP_W-1:0] recip;
  fsrd_pkg::chan_ctrl_t       ctrl;
  logic [PW-1:0]              ch_out  [NC];
  logic [EW-1:0]              ch_prev [NC];
  logic [EW-1:0]              ch_npb  [NC];

  // Handshake.
  assign in_ready = (state == ST_IDLE) && !recip_busy;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Effective levels and row width.
  assign lv     = (levels == '0) ? PW'(1) : levels;
  assign cfg_lv = (cfg_data[PW-1:0] == '0) ? PW'(1) : cfg_data[PW-1:0];
  assign w_raw  = CW'(line_width);
  always_comb begin
    if (w_raw < CW'(fsrd_pkg::MIN_WIDTH)) begin
      w_eff = CW'(fsrd_pkg::MIN_WIDTH);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end
  assign w_last   = AW'(w_eff - CW'(1));
  assign col_base = frame_start ? '0 : column_count;
  assign c_in     = (col_base > w_last) ? w_last : col_base;

  // Configuration registers; a levels write restarts the reciprocal.
  assign recip_start = cfg_write && (cfg_index == fsrd_pkg::REG_LEVELS);
  always_ff @(posedge clk) begin
    if (rst) begin
      levels     <= fsrd_pkg::LEVELS_RESET;
      line_width <= fsrd_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fsrd_pkg::REG_LEVELS:     levels     <= cfg_data[PW-1:0];
        fsrd_pkg::REG_LINE_WIDTH: line_width <= cfg_data[fsrd_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  fsrd_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (recip_start),
    .divisor (cfg_lv),
    .recip   (recip),
    .busy    (recip_busy)
  );

  // Stage strobes for the channel datapaths.
  always_comb begin
    ctrl        = '0;
    ctrl.clear  = in_fire && frame_start;
    ctrl.sum    = (state == ST_SUM);
    ctrl.mul1   = (state == ST_MUL1);
    ctrl.mul2   = (state == ST_MUL2);
    ctrl.mul3   = (state == ST_MUL3);
    ctrl.commit = (state == ST_COMMIT) && out_free;
  end

  // Channel datapaths; the line buffer word holds red, green and blue from the bottom.
  for (genvar ch = 0; ch < NC; ch++) begin : g_ch
    logic signed [EW-1:0] below;
    assign below = first_row ? '0 : $signed(rd_data[ch*EW +: EW]);

    fsrd_chan u_chan (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .pix_in  (pix[ch]),
      .below   (below),
      .lv      (lv),
      .recip   (recip),
      .last    (last_col),
      .pix_out (ch_out[ch]),
      .wr_prev (ch_prev[ch]),
      .npb     (ch_npb[ch])
    );
  end

  // Line buffer write: down-left share at commit, the held down share at row end.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = col;
    wr_data = last_data;
    if (ctrl.commit && (col != '0)) begin
      mem_we  = 1'b1;
      wr_addr = col - AW'(1);
      wr_data = {ch_prev[2], ch_prev[1], ch_prev[0]};
    end else if (state == ST_WLAST) begin
      mem_we = 1'b1;
    end
  end

  // Line buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_buf[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_data <= line_buf[c_in];
    end
  end

  // Pixel transaction registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix[0]   <= red_in;
      pix[1]   <= green_in;
      pix[2]   <= blue_in;
      col      <= c_in;
      last_col <= (c_in == w_last);
    end
    if (ctrl.commit) begin
      last_data <= {ch_npb[2], ch_npb[1], ch_npb[0]};
    end
  end

  // Sequencer with row position and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      first_row    <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !ctrl.commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (frame_start) begin
              first_row <= 1'b1;
            end
            state <= ST_SUM;
          end
        end
        ST_SUM:  state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_MUL3;
        ST_MUL3: state <= ST_COMMIT;
        ST_COMMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            red_out   <= ch_out[0];
            green_out <= ch_out[1];
            blue_out  <= ch_out[2];
            if (last_col) begin
              column_count <= '0;
              first_row    <= 1'b0;
              state        <= ST_WLAST;
            end else begin
              column_count <= col + AW'(1);
              state        <= ST_IDLE;
            end
          end
        end
        ST_WLAST: state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fsrd_pkg::*;

  localparam int W_MAX = MAX_WIDTH_DEFAULT;
  localparam int IDLE_LIMIT = 4000;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_t;

  typedef struct {
    rgb_t rgb;
    logic fs;
  } pixel_item_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKE} rx_mode_t;
  typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_FLAT} pix_style_t;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] red_in = '0;
  logic [PIX_W-1:0] green_in = '0;
  logic [PIX_W-1:0] blue_in = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_LEVELS;
  logic [CFG_W-1:0] cfg_data = '0;

  floyd_steinberg_rgb_dither_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pixels waiting to be driven and dithered pixels waiting to be seen.
  pixel_item_t pending_pixels[$];
  rgb_t expected_pixels[$];
  int pixel_errors = 0;
  string chan_name [NUM_CH] = '{"red", "green", "blue"};

  // Dither state mirrored by the testbench.
  logic [PIX_W-1:0] cur_levels = LEVELS_RESET;
  logic [LINE_W-1:0] cur_width = WIDTH_RESET;
  logic signed [ERR_W-1:0] row_err [NUM_CH][W_MAX];
  logic signed [ERR_W-1:0] carry_right [NUM_CH];
  logic signed [ERR_W-1:0] below_acc [NUM_CH];
  logic signed [ERR_W-1:0] below_right_acc [NUM_CH];
  int col_pos = 0;
  bit in_first_row = 1'b1;

  function automatic int err_share(input int e, input int num);
    if (e < 0) return -(((-e) * num) / 16);
    return (e * num) / 16;
  endfunction

  function automatic void clear_carries();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      carry_right[ch] = '0;
      below_acc[ch] = '0;
      below_right_acc[ch] = '0;
    end
  endfunction

  // Works out the dithered pixel for one accepted input and advances the state.
  task automatic dither_predict(input rgb_t pix, input logic fs);
    int lv, wd, col;
    int below, v, q, o, e, npb;
    bit last_col;
    rgb_t res;
    lv = (cur_levels == '0) ? 1 : int'(cur_levels);
    wd = int'(cur_width);
    if (wd < MIN_WIDTH) wd = MIN_WIDTH;
    if (wd > W_MAX) wd = W_MAX;
    if (fs) begin
      clear_carries();
      col_pos = 0;
      in_first_row = 1'b1;
    end
    col = (col_pos > wd - 1) ? wd - 1 : col_pos;
    last_col = (col == wd - 1);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      below = in_first_row ? 0 : int'(row_err[ch][col]);
      v = int'(pix[ch]) + int'(carry_right[ch]) + below;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      q = (2 * lv * v + 255) / 510;
      o = (q * 255) / lv;
      res[ch] = PIX_W'(o);
      e = v - o;
      if (col > 0) row_err[ch][col - 1] = ERR_W'(int'(below_acc[ch]) + err_share(e, 3));
      npb = int'(below_right_acc[ch]) + err_share(e, 5);
      if (last_col) begin
        row_err[ch][col] = ERR_W'(npb);
        carry_right[ch] = '0;
        below_acc[ch] = '0;
        below_right_acc[ch] = '0;
      end else begin
        carry_right[ch] = ERR_W'(err_share(e, 7));
        below_acc[ch] = ERR_W'(npb);
        below_right_acc[ch] = ERR_W'(err_share(e, 1));
      end
    end
    if (last_col) begin
      col_pos = 0;
      in_first_row = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    expected_pixels.push_back(res);
  endtask

  // Input driver: bursts of random length separated by random gaps.
  pixel_item_t drv_item;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        drv_item = pending_pixels.pop_front();
        in_valid <= 1'b1;
        red_in <= drv_item.rgb[0];
        green_in <= drv_item.rgb[1];
        blue_in <= drv_item.rgb[2];
        frame_start <= drv_item.fs;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          if ($urandom_range(0, 15) == 0) gap_left = $urandom_range(20, 60);
          else if ($urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver: stall pattern that changes mode every so often.
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Monitor: checks each output transaction, then predicts each input transaction.
  rgb_t mon_want;
  rgb_t mon_got;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        mon_got = {blue_out, green_out, red_out};
        if (expected_pixels.size() == 0) begin
          $display("%0t: output pixel with none expected, expected nothing, actual %0d %0d %0d",
                   $time, red_out, green_out, blue_out);
          pixel_errors++;
        end else begin
          mon_want = expected_pixels.pop_front();
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (mon_got[ch] !== mon_want[ch]) begin
              $display("%0t: %s mismatch, expected %0d, actual %0d",
                       $time, chan_name[ch], mon_want[ch], mon_got[ch]);
              pixel_errors++;
            end
          end
        end
      end
      if (in_valid && in_ready)
        dither_predict({blue_in, green_in, red_in}, frame_start);
    end
  end

  // Watchdog on cycles in which no transaction happens on either channel.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_LEVELS) cur_levels = data[PIX_W-1:0];
    else cur_width = data[LINE_W-1:0];
    @(negedge clk);
  endtask

  task automatic push_pixel(input int r, input int g, input int b, input logic fs);
    pixel_item_t item;
    item.rgb = {PIX_W'(b), PIX_W'(g), PIX_W'(r)};
    item.fs = fs;
    pending_pixels.push_back(item);
  endtask

  // Random pixels in runs of noise, saturated extremes or nearly flat colour.
  task automatic queue_pixels(input int count, input bit new_frame);
    pix_style_t style;
    int run;
    logic [PIX_W-1:0] base;
    pixel_item_t item;
    run = 0;
    style = PIX_NOISE;
    base = '0;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        style = pix_style_t'($urandom_range(0, 2));
        run = $urandom_range(4, 20);
        base = PIX_W'($urandom_range(0, 255));
      end
      run--;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        case (style)
          PIX_NOISE: item.rgb[ch] = PIX_W'($urandom_range(0, 255));
          PIX_EXTREME: item.rgb[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: item.rgb[ch] = base + PIX_W'($urandom_range(0, 6)) - 8'd3;
        endcase
      end
      item.fs = (i == 0 && new_frame) || ($urandom_range(0, 99) == 0);
      pending_pixels.push_back(item);
    end
  endtask

  // Waits until every pixel is driven and checked, then lets the pipeline drain.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    logic [PIX_W-1:0] lv_pick;
    logic [LINE_W-1:0] wd_pick;
    for (int ch = 0; ch < NUM_CH; ch++)
      for (int c = 0; c < W_MAX; c++)
        row_err[ch][c] = '0;
    clear_carries();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: the first row runs from reset without a frame marker.
    push_pixel(0, 0, 0, 1'b0);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(255, 0, 128, 1'b0);
    push_pixel(127, 128, 1, 1'b0);
    push_pixel(1, 254, 64, 1'b1);
    push_pixel(200, 100, 50, 1'b0);
    wait_idle();

    // Width below the minimum saturates to two columns; zero levels acts as one.
    write_reg(REG_LINE_WIDTH, 12'd0);
    write_reg(REG_LEVELS, 12'h000);
    push_pixel(255, 255, 255, 1'b1);
    push_pixel(0, 0, 0, 1'b0);
    push_pixel(128, 128, 128, 1'b0);
    push_pixel(127, 127, 127, 1'b0);
    push_pixel(255, 0, 255, 1'b0);
    push_pixel(0, 255, 0, 1'b0);
    push_pixel(64, 192, 32, 1'b0);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(0, 0, 0, 1'b0);
    wait_idle();

    // Width of one also saturates; the upper data bits of a levels write are dropped.
    write_reg(REG_LINE_WIDTH, 12'd1);
    write_reg(REG_LEVELS, 12'hFFF);
    push_pixel(0, 0, 0, 1'b1);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(1, 2, 3, 1'b0);
    push_pixel(254, 253, 252, 1'b0);
    push_pixel(128, 127, 129, 1'b0);
    push_pixel(0, 255, 128, 1'b0);
    push_pixel(77, 177, 250, 1'b0);
    wait_idle();

    // Random frames under a spread of settings.
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 5))
        0: lv_pick = 8'd0;
        1: lv_pick = 8'd1;
        2: lv_pick = 8'd255;
        3: lv_pick = PIX_W'($urandom_range(2, 8));
        default: lv_pick = PIX_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 4))
        0: wd_pick = LINE_W'($urandom_range(0, 2));
        1: wd_pick = LINE_W'($urandom_range(25, 64));
        default: wd_pick = LINE_W'($urandom_range(3, 24));
      endcase
      write_reg(REG_LEVELS, {4'($urandom_range(0, 15)), lv_pick});
      write_reg(REG_LINE_WIDTH, wd_pick);
      queue_pixels($urandom_range(40, 80), 1'b1);
      wait_idle();
    end

    // Narrower width and new levels in the middle of a row, with no forced frame restart.
    write_reg(REG_LEVELS, 12'd2);
    write_reg(REG_LINE_WIDTH, 12'd12);
    queue_pixels(20, 1'b1);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 12'd5);
    write_reg(REG_LEVELS, 12'd6);
    queue_pixels(30, 1'b0);
    wait_idle();

    // Widest line register value, which saturates to the buffer depth.
    write_reg(REG_LEVELS, {4'd0, PIX_W'($urandom_range(1, 255))});
    write_reg(REG_LINE_WIDTH, 12'hFFF);
    queue_pixels(300, 1'b1);
    wait_idle();

    if (pixel_errors == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/fsrd_pkg.sv
design/fsrd_recip.sv
design/fsrd_chan.sv
design/floyd_steinberg_rgb_dither_unit.sv
sim/tb_top.sv
